>>> hw/rtl/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants of the console line editor: line store size,
// command and result records, result kinds and ASCII codes.
// ----------------------------------------------------------------------------
package cle_pkg;

   // Line store geometry
   localparam int LINE_CAPACITY = 32;
   localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);
   localparam int ADDR_W        = $clog2(LINE_CAPACITY);

   // Command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   // Result queue at the output
   localparam int RSPQ_DEPTH = 2;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   // Command codes
   localparam logic [1:0] OP_PRINT = 2'd0;
   localparam logic [1:0] OP_ERASE = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_ENDL  = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_TERM = 2'd0;
   localparam logic [1:0] KIND_LINE = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   // ASCII codes
   localparam logic [7:0] CHAR_ETX   = 8'd3;
   localparam logic [7:0] CHAR_ACK   = 8'd6;
   localparam logic [7:0] CHAR_BS    = 8'd8;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_NAK   = 8'd21;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_TILDE = 8'd126;
   localparam logic [7:0] CHAR_DEL   = 8'd127;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] ch;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } rsp_type;

endpackage

>>> hw/rtl/cle_front.sv
// ----------------------------------------------------------------------------
// cle_front
// Accepts received bytes, sorts them into editor commands and holds them in
// a short command queue for the back end. Bytes without meaning are dropped.
// ----------------------------------------------------------------------------
module cle_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [7:0]        req_rx_byte,
   output logic              cmd_vld,
   output cle_pkg::cmd_type  cmd,
   input  logic              cmd_pop
);

   localparam int CMDQ_CNT_W = cle_pkg::CMDQ_CNT_W;

   cle_pkg::cmd_type                    q_ff [cle_pkg::CMDQ_DEPTH];
   logic [cle_pkg::CMDQ_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [cle_pkg::CMDQ_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [cle_pkg::CMDQ_CNT_W-1:0]      count_ff, count_in;
   logic                                keep;
   logic [1:0]                          op;
   logic                                wr;
   logic                                rd;

   // Classify the byte
   always_comb begin
      keep = 1'b1;
      op   = cle_pkg::OP_PRINT;
      case (req_rx_byte) inside
         cle_pkg::CHAR_CR, cle_pkg::CHAR_LF: op = cle_pkg::OP_ENDL;
         cle_pkg::CHAR_ETX:                  op = cle_pkg::OP_CLEAR;
         cle_pkg::CHAR_BS, cle_pkg::CHAR_DEL: op = cle_pkg::OP_ERASE;
         [cle_pkg::CHAR_SPACE:cle_pkg::CHAR_TILDE]: op = cle_pkg::OP_PRINT;
         default:                            keep = 1'b0;
      endcase
   end

   assign req_full = (count_ff == cle_pkg::CMDQ_CNT_W'(cle_pkg::CMDQ_DEPTH));
   assign cmd_vld  = (count_ff != '0);
   assign cmd      = q_ff[rd_ptr_ff];
   assign wr       = req_push && !req_full && keep;
   assign rd       = cmd_pop && cmd_vld;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CMDQ_CNT_W'(wr) - CMDQ_CNT_W'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the command
   always_ff @(posedge clock) begin
      if (wr) begin
         q_ff[wr_ptr_ff] <= '{op: op, ch: req_rx_byte};
      end
   end

endmodule

>>> hw/rtl/cle_back.sv
// ----------------------------------------------------------------------------
// cle_back
// Carries out editor commands: keeps the line store and length, checks the
// line checksum by a walk over the store, and sends terminal text, line
// bytes and the end marker one per step into the result queue.
// ----------------------------------------------------------------------------
module cle_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              echo_en,
   input  logic              cksum_en,
   input  logic              cmd_vld,
   input  cle_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   input  logic              rsp_room,
   output logic              rsp_push,
   output cle_pkg::rsp_type  rsp_item
);

   localparam int LEN_W  = cle_pkg::LEN_W;
   localparam int ADDR_W = cle_pkg::ADDR_W;

   // Sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SUM_RD  = 3'd1;
   localparam logic [2:0] S_SUM_ACC = 3'd2;
   localparam logic [2:0] S_MSG     = 3'd3;
   localparam logic [2:0] S_LINE_RD = 3'd4;
   localparam logic [2:0] S_LINE_WR = 3'd5;
   localparam logic [2:0] S_END     = 3'd6;

   // Terminal messages
   localparam logic [2:0] MSG_ECHO  = 3'd0;
   localparam logic [2:0] MSG_ERASE = 3'd1;
   localparam logic [2:0] MSG_BANG  = 3'd2;
   localparam logic [2:0] MSG_CRLF  = 3'd3;
   localparam logic [2:0] MSG_ACK   = 3'd4;
   localparam logic [2:0] MSG_NAK   = 3'd5;

   function automatic logic [2:0] msg_last_pos(input logic [2:0] msg);
      logic [2:0] r;
      unique case (msg)
         MSG_ECHO:           r = 3'd0;
         MSG_ERASE, MSG_BANG: r = 3'd2;
         MSG_CRLF:           r = 3'd1;
         default:            r = 3'd5;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] msg_char(input logic [2:0] msg, input logic [2:0] pos,
                                           input logic [7:0] ch);
      logic [7:0] r;
      unique case (msg)
         MSG_ECHO:  r = ch;
         MSG_ERASE: r = (pos == 3'd1) ? cle_pkg::CHAR_SPACE : cle_pkg::CHAR_BS;
         MSG_BANG: begin
            case (pos)
               3'd0:    r = "!";
               3'd1:    r = cle_pkg::CHAR_CR;
               default: r = cle_pkg::CHAR_LF;
            endcase
         end
         MSG_CRLF:  r = (pos == 3'd0) ? cle_pkg::CHAR_CR : cle_pkg::CHAR_LF;
         MSG_ACK: begin
            case (pos)
               3'd0:    r = cle_pkg::CHAR_ACK;
               3'd1:    r = "A";
               3'd2:    r = "C";
               3'd3:    r = "K";
               3'd4:    r = cle_pkg::CHAR_CR;
               default: r = cle_pkg::CHAR_LF;
            endcase
         end
         default: begin
            case (pos)
               3'd0:    r = cle_pkg::CHAR_NAK;
               3'd1:    r = "N";
               3'd2:    r = "A";
               3'd3:    r = "K";
               3'd4:    r = cle_pkg::CHAR_CR;
               default: r = cle_pkg::CHAR_LF;
            endcase
         end
      endcase
      return r;
   endfunction

   // Hex digit decode: {valid, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      if (c >= "0" && c <= "9") begin
         r = {1'b1, 4'(c - "0")};
      end else if (c >= "A" && c <= "F") begin
         r = {1'b1, 4'(c - "A" + 8'd10)};
      end else if (c >= "a" && c <= "f") begin
         r = {1'b1, 4'(c - "a" + 8'd10)};
      end else begin
         r = 5'd0;
      end
      return r;
   endfunction

   logic [7:0]        store_mem [cle_pkg::LINE_CAPACITY];
   logic [7:0]        rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;

   logic [2:0]        state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [2:0]        msg_ff, msg_in;
   logic [2:0]        pos_ff, pos_in;
   logic [7:0]        ch_ff, ch_in;
   logic              line_ff, line_in;
   logic [7:0]        sum_ff, sum_in;
   logic              bad_ff, bad_in;

   logic [LEN_W-1:0]  len_m1;
   logic              idx_at_end;
   logic [4:0]        hex;

   assign len_m1     = len_ff - 1'b1;
   assign idx_at_end = (LEN_W'(idx_ff) == len_m1);
   assign hex        = hex_decode(rd_data_ff);

   // Sequence one command
   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      msg_in   = msg_ff;
      pos_in   = pos_ff;
      ch_in    = ch_ff;
      line_in  = line_ff;
      sum_in   = sum_ff;
      bad_in   = bad_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      rsp_item = '{kind: cle_pkg::KIND_TERM, data: 8'd0, last: 1'b0};
      mem_we   = 1'b0;
      mem_wa   = len_ff[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_vld) begin
               cmd_pop = 1'b1;
               ch_in   = cmd.ch;
               pos_in  = 3'd0;
               line_in = 1'b0;
               idx_in  = '0;
               sum_in  = 8'd0;
               bad_in  = 1'b0;
               unique case (cmd.op)
                  cle_pkg::OP_PRINT: begin
                     if (len_ff < LEN_W'(cle_pkg::LINE_CAPACITY)) begin
                        mem_we = 1'b1;
                        len_in = len_ff + 1'b1;
                        msg_in = MSG_ECHO;
                        if (echo_en) state_in = S_MSG;
                     end
                  end
                  cle_pkg::OP_ERASE: begin
                     if (len_ff != '0) begin
                        len_in = len_m1;
                        msg_in = MSG_ERASE;
                        if (echo_en) state_in = S_MSG;
                     end
                  end
                  cle_pkg::OP_CLEAR: begin
                     len_in = '0;
                     msg_in = MSG_BANG;
                     if (echo_en) state_in = S_MSG;
                  end
                  default: begin
                     if (!cksum_en) begin
                        line_in = 1'b1;
                        msg_in  = MSG_CRLF;
                        if (echo_en)           state_in = S_MSG;
                        else if (len_ff == '0) state_in = S_END;
                        else                   state_in = S_LINE_RD;
                     end else if (len_ff < LEN_W'(2)) begin
                        msg_in   = MSG_NAK;
                        len_in   = '0;
                        state_in = S_MSG;
                     end else begin
                        state_in = S_SUM_RD;
                     end
                  end
               endcase
            end
         end

         S_SUM_RD: state_in = S_SUM_ACC;

         // Add one stored byte; the first two are hex digits
         S_SUM_ACC: begin
            if (idx_ff == '0) begin
               sum_in = sum_ff + {hex[3:0], 4'd0};
               bad_in = bad_ff | !hex[4];
            end else if (idx_ff == ADDR_W'(1)) begin
               sum_in = sum_ff + {4'd0, hex[3:0]};
               bad_in = bad_ff | !hex[4];
            end else begin
               sum_in = sum_ff + rd_data_ff;
            end
            if (idx_at_end) begin
               state_in = S_MSG;
               if (!bad_in && sum_in == 8'd0) begin
                  msg_in  = MSG_ACK;
                  line_in = 1'b1;
               end else begin
                  msg_in  = MSG_NAK;
                  line_in = 1'b0;
                  len_in  = '0;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SUM_RD;
            end
         end

         S_MSG: begin
            if (rsp_room) begin
               rsp_push = 1'b1;
               rsp_item = '{kind: cle_pkg::KIND_TERM,
                            data: msg_char(msg_ff, pos_ff, ch_ff),
                            last: (pos_ff == msg_last_pos(msg_ff)) && !line_ff};
               pos_in   = pos_ff + 1'b1;
               if (pos_ff == msg_last_pos(msg_ff)) begin
                  idx_in = '0;
                  if (!line_ff)          state_in = S_IDLE;
                  else if (len_ff == '0) state_in = S_END;
                  else                   state_in = S_LINE_RD;
               end
            end
         end

         S_LINE_RD: state_in = S_LINE_WR;

         S_LINE_WR: begin
            if (rsp_room) begin
               rsp_push = 1'b1;
               rsp_item = '{kind: cle_pkg::KIND_LINE, data: rd_data_ff, last: 1'b0};
               if (idx_at_end) begin
                  state_in = S_END;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_LINE_RD;
               end
            end
         end

         S_END: begin
            if (rsp_room) begin
               rsp_push = 1'b1;
               rsp_item = '{kind: cle_pkg::KIND_END, data: 8'd0, last: 1'b1};
               len_in   = '0;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
      end
   end

   // Hold working payload
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      msg_ff  <= msg_in;
      pos_ff  <= pos_in;
      ch_ff   <= ch_in;
      line_ff <= line_in;
      sum_ff  <= sum_in;
      bad_ff  <= bad_in;
   end

   // Line store: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_wa] <= cmd.ch;
      end
      rd_data_ff <= store_mem[idx_ff];
   end

endmodule

>>> hw/rtl/cle_rsp_fifo.sv
// ----------------------------------------------------------------------------
// cle_rsp_fifo
// Two-entry result queue; parts the back end from the result receiver so
// that a stalled receiver only holds the sequencer.
// ----------------------------------------------------------------------------
module cle_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cle_pkg::rsp_type  push_item,
   output logic              room,
   output logic              empty,
   input  logic              pop,
   output cle_pkg::rsp_type  head
);

   localparam int CNT_W = cle_pkg::RSPQ_CNT_W;

   cle_pkg::rsp_type                 q_ff [cle_pkg::RSPQ_DEPTH];
   logic [cle_pkg::RSPQ_PTR_W-1:0]   wr_ptr_ff;
   logic [cle_pkg::RSPQ_PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic                             wr;
   logic                             rd;

   assign room  = (count_ff != CNT_W'(cle_pkg::RSPQ_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = q_ff[rd_ptr_ff];
   assign wr    = push && room;
   assign rd    = pop && !empty;
   assign count_in = count_ff + CNT_W'(wr) - CNT_W'(rd);

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (rd) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   // Store the item
   always_ff @(posedge clock) begin
      if (wr) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> hw/rtl/console_line_editor_checksum.sv
// ----------------------------------------------------------------------------
// console_line_editor_checksum
// Serial console line editor with optional two-digit hex line checksum.
//
// Input queue: drive req_rx_byte with req_push; a byte is taken when
// req_full is low. Printable bytes grow the line, backspace/DEL and Ctrl-C
// edit it, CR/LF ends it. Other bytes are dropped at the input.
// Result queue: while rsp_empty is low, rsp_kind/rsp_data/rsp_last show the
// oldest result; rsp_pop takes it. rsp_last marks the final result of the
// byte that caused it.
// Config: csr_index 0 is echo enable (reset 1), 1 is checksum enable
// (reset 0); csr_ready is always high. Write only while the block is idle.
// Flow: a command queue of two holds bytes while the sequencer works.
// The sequencer takes an editing byte in its idle state, then sends each
// echoed terminal byte in its message state. A line end runs the checksum
// walk first when enabled, then sends the reply bytes, then each line byte
// through a read state and a send state, set by the single read port of the store.
// A stalled receiver fills the two-entry result queue, then holds the
// sequencer, then fills the command queue and raises req_full.
// Reset empties both queues and the line, and restores the config values.
// ----------------------------------------------------------------------------
module console_line_editor_checksum (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic       csr_data
);

   localparam logic CSR_ECHO = 1'b0;

   logic              echo_enable_ff;
   logic              checksum_enable_ff;
   logic              cmd_vld;
   cle_pkg::cmd_type  cmd;
   logic              cmd_pop;
   logic              rsp_room;
   logic              rsp_push;
   cle_pkg::rsp_type  rsp_item;
   cle_pkg::rsp_type  rsp_head;

   assign csr_ready = 1'b1;

   // Write config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         echo_enable_ff     <= 1'b1;
         checksum_enable_ff <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == CSR_ECHO) echo_enable_ff     <= csr_data;
         else                       checksum_enable_ff <= csr_data;
      end
   end

   cle_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_rx_byte (req_rx_byte),
      .cmd_vld     (cmd_vld),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   cle_back u_back (
      .clock    (clock),
      .reset    (reset),
      .echo_en  (echo_enable_ff),
      .cksum_en (checksum_enable_ff),
      .cmd_vld  (cmd_vld),
      .cmd      (cmd),
      .cmd_pop  (cmd_pop),
      .rsp_room (rsp_room),
      .rsp_push (rsp_push),
      .rsp_item (rsp_item)
   );

   cle_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_item (rsp_item),
      .room      (rsp_room),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .head      (rsp_head)
   );

   assign rsp_kind = rsp_head.kind;
   assign rsp_data = rsp_head.data;
   assign rsp_last = rsp_head.last;

endmodule
